### rtl/core/wrpe_pkg.sv
`timescale 1ns / 1ps
package wrpe_pkg;

    localparam int FRAC_BITS_DEF = 4;
    localparam int CORDIC_STEPS  = 14;
    localparam int CORDIC_GUARD  = 16;
    localparam int ANGLE_FRAC    = 12;
    localparam int RNG_W         = 13;
    localparam int LEN_W         = 14;
    localparam int OFS_W         = 10;
    localparam int POS_W         = 15;
    localparam int HDG_W         = 12;
    localparam int CFG_AW        = 3;
    localparam int CFG_DW        = 14;
    // Rotator datapath widths: x and y carry 16 guard bits and the CORDIC gain.
    localparam int XY_W          = 34;
    localparam int Z_W           = 22;

    localparam logic [CFG_AW-1:0] CFG_IR_THR    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SONAR_THR = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TBL_WIDTH = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TBL_LEN   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_SIDE_OFS  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_FRONT_OFS = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_BACK_OFS  = 3'd6;

    typedef struct packed {
        logic [RNG_W-1:0] ir_thr;
        logic [RNG_W-1:0] sonar_thr;
        logic [LEN_W-1:0] tbl_width;
        logic [LEN_W-1:0] tbl_len;
        logic [OFS_W-1:0] side_ofs;
        logic [OFS_W-1:0] front_ofs;
        logic [OFS_W-1:0] back_ofs;
    } t_cfg;

    // Results that are final before the rotator, carried alongside it.
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    front_wall;
        logic                    hdg_neg;
        logic                    hdg_zero;
    } t_side;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        t_side                  side;
    } t_stage;

    // atan(2^-i) in degrees, scaled by 2^ANGLE_FRAC and rounded.
    function automatic logic signed [Z_W-1:0] atan_entry(input int step);
        logic signed [Z_W-1:0] v;
        case (step)
            0:       v = Z_W'(184320);
            1:       v = Z_W'(108810);
            2:       v = Z_W'(57492);
            3:       v = Z_W'(29184);
            4:       v = Z_W'(14649);
            5:       v = Z_W'(7331);
            6:       v = Z_W'(3667);
            7:       v = Z_W'(1833);
            8:       v = Z_W'(917);
            9:       v = Z_W'(458);
            10:      v = Z_W'(229);
            11:      v = Z_W'(115);
            12:      v = Z_W'(57);
            13:      v = Z_W'(29);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/wrpe_prep.sv
`timescale 1ns / 1ps
module wrpe_prep import wrpe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  t_cfg             i_cfg,
    input  logic [RNG_W-1:0] i_ir_front_left,
    input  logic [RNG_W-1:0] i_ir_front_right,
    input  logic [RNG_W-1:0] i_ir_back_left,
    input  logic [RNG_W-1:0] i_ir_back_right,
    input  logic [RNG_W-1:0] i_sonar_range,
    output logic             o_valid,
    output t_stage           o_stage
);

    localparam logic signed [XY_W-1:0] X_INIT = XY_W'(10) << (FRAC_BITS + CORDIC_GUARD);
    localparam logic signed [17:0] POS_HI = 18'sd16383;
    localparam logic signed [17:0] POS_LO = -18'sd16384;

    logic                    r_valid;
    t_stage                  r_stage;
    t_stage                  n_stage;
    logic                    left_near;
    logic                    right_near;
    logic                    front;
    logic signed [17:0]      left2;
    logic signed [17:0]      right2;
    logic signed [17:0]      px_full;
    logic signed [15:0]      py_full;
    logic signed [RNG_W:0]   diff;
    logic        [RNG_W-1:0] mag;

    always_comb begin
        front      = i_sonar_range < i_cfg.sonar_thr;
        left_near  = (i_ir_front_left < i_cfg.ir_thr) || (i_ir_back_left < i_cfg.ir_thr);
        right_near = (i_ir_front_right < i_cfg.ir_thr) || (i_ir_back_right < i_cfg.ir_thr);

        // Doubled side estimates keep the half units exact.
        left2  = $signed(18'(i_ir_front_left)) + $signed(18'(i_ir_back_left))
               + $signed(18'({i_cfg.side_ofs, 1'b0}));
        right2 = $signed(18'({i_cfg.tbl_width, 1'b0})) - $signed(18'(i_ir_front_right))
               - $signed(18'(i_ir_back_right)) - $signed(18'({i_cfg.side_ofs, 1'b0}));

        if (left_near && !right_near) begin
            px_full = (left2 + 18'sd1) >>> 1;
        end else if (right_near && !left_near) begin
            px_full = (right2 + 18'sd1) >>> 1;
        end else if (left_near && right_near) begin
            px_full = (left2 + right2 + 18'sd2) >>> 2;
        end else begin
            px_full = $signed(18'(i_cfg.tbl_width) + 18'd1) >>> 1;
        end
        if (px_full > POS_HI) begin
            px_full = POS_HI;
        end else if (px_full < POS_LO) begin
            px_full = POS_LO;
        end

        if (front) begin
            py_full = $signed(16'(i_sonar_range)) + $signed(16'(i_cfg.front_ofs));
        end else begin
            py_full = $signed(16'(i_cfg.tbl_len)) - $signed(16'(i_cfg.back_ofs));
        end

        if (left_near) begin
            diff = $signed({1'b0, i_ir_front_left}) - $signed({1'b0, i_ir_back_left});
        end else begin
            diff = $signed({1'b0, i_ir_front_right}) - $signed({1'b0, i_ir_back_right});
        end
        mag = diff[RNG_W] ? RNG_W'(-diff) : diff[RNG_W-1:0];

        n_stage.x               = X_INIT;
        n_stage.y               = $signed(XY_W'(mag) << CORDIC_GUARD);
        n_stage.z               = '0;
        n_stage.side.pos_x      = px_full[POS_W-1:0];
        n_stage.side.pos_y      = py_full[POS_W-1:0];
        n_stage.side.front_wall = front;
        // The right side mirrors the angle.
        n_stage.side.hdg_neg    = left_near ? diff[RNG_W] : (diff > 0);
        n_stage.side.hdg_zero   = (diff == 0) || !(left_near || right_near);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### rtl/core/wrpe_cell.sv
`timescale 1ns / 1ps
module wrpe_cell import wrpe_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_stage o_stage
);

    localparam logic signed [Z_W-1:0] ANGLE = atan_entry(STEP);

    logic                   r_valid;
    t_stage                 r_stage;
    t_stage                 n_stage;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    // One vectoring micro-rotation: drive y toward zero, accumulate the angle.
    always_comb begin
        xs      = i_stage.x >>> STEP;
        ys      = i_stage.y >>> STEP;
        n_stage = i_stage;
        if (!i_stage.y[XY_W-1]) begin
            n_stage.x = i_stage.x + ys;
            n_stage.y = i_stage.y - xs;
            n_stage.z = i_stage.z + ANGLE;
        end else begin
            n_stage.x = i_stage.x - ys;
            n_stage.y = i_stage.y + xs;
            n_stage.z = i_stage.z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### rtl/core/wrpe_post.sv
`timescale 1ns / 1ps
module wrpe_post import wrpe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  t_stage                  i_stage,
    output logic                    o_valid,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [HDG_W-1:0] o_heading,
    output logic                    o_front_wall
);

    localparam int                    SH     = ANGLE_FRAC - FRAC_BITS;
    localparam logic signed [Z_W-1:0] HALF   = (SH > 0) ? (Z_W'(1) << (SH - 1)) : '0;
    localparam logic signed [Z_W-1:0] R_MAX  = Z_W'(90) << FRAC_BITS;
    localparam logic signed [Z_W-1:0] HDG_HI = Z_W'((1 << (HDG_W - 1)) - 1);
    localparam logic signed [Z_W-1:0] HDG_LO = -(Z_W'(1) << (HDG_W - 1));

    logic                    r_valid;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic signed [HDG_W-1:0] r_heading;
    logic                    r_front_wall;
    logic signed [HDG_W-1:0] n_heading;
    logic signed [Z_W-1:0]   rnd;
    logic signed [Z_W-1:0]   hv;

    always_comb begin
        rnd = (i_stage.z + HALF) >>> SH;
        if (rnd < 0) begin
            rnd = '0;
        end else if (rnd > R_MAX) begin
            rnd = R_MAX;
        end
        hv = i_stage.side.hdg_neg ? -rnd : rnd;
        if (hv > HDG_HI) begin
            hv = HDG_HI;
        end else if (hv < HDG_LO) begin
            hv = HDG_LO;
        end
        n_heading = i_stage.side.hdg_zero ? '0 : hv[HDG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pos_x      <= i_stage.side.pos_x;
            r_pos_y      <= i_stage.side.pos_y;
            r_heading    <= n_heading;
            r_front_wall <= i_stage.side.front_wall;
        end
    end

    assign o_valid      = r_valid;
    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_heading    = r_heading;
    assign o_front_wall = r_front_wall;

endmodule

### rtl/core/wall_range_pose_estimator.sv
`timescale 1ns / 1ps
// Pose estimator for a robot on a rectangular table.
// Input channel (i_in_valid / o_in_stall): one transaction carries four side IR
// ranges and the front sonar range. Output channel (o_out_valid / i_out_stall):
// one transaction per input carries x, y, heading and the front wall flag.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata while
// the block is idle; addresses beyond the register list are ignored.
// Range preparation is done in the accepting cycle and is registered at that
// edge. Each of the 14 cells of the pipelined CORDIC rotator then registers one
// micro-rotation, and angle rounding is registered in the output register.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the rotator chain taking a new vector in every cycle that it is not
// held.
// When the receiver stalls while a result is shown, the whole chain holds and
// o_in_stall rises in the same cycle; nothing in flight is lost.
// Synchronous reset empties the chain and loads the configuration defaults.
module wall_range_pose_estimator import wrpe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_addr,
    input  logic [CFG_DW-1:0]       i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [RNG_W-1:0]        i_ir_front_left,
    input  logic [RNG_W-1:0]        i_ir_front_right,
    input  logic [RNG_W-1:0]        i_ir_back_left,
    input  logic [RNG_W-1:0]        i_ir_back_right,
    input  logic [RNG_W-1:0]        i_sonar_range,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [HDG_W-1:0] o_heading,
    output logic                    o_front_wall
);

    t_cfg   r_cfg;
    logic   adv;
    logic   cell_valid [0:CORDIC_STEPS];
    t_stage cell_stage [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ir_thr    <= RNG_W'(240);
            r_cfg.sonar_thr <= RNG_W'(800);
            r_cfg.tbl_width <= LEN_W'(1600);
            r_cfg.tbl_len   <= LEN_W'(3200);
            r_cfg.side_ofs  <= OFS_W'(48);
            r_cfg.front_ofs <= OFS_W'(184);
            r_cfg.back_ofs  <= OFS_W'(184);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IR_THR:    r_cfg.ir_thr    <= i_cfg_wdata[RNG_W-1:0];
                CFG_SONAR_THR: r_cfg.sonar_thr <= i_cfg_wdata[RNG_W-1:0];
                CFG_TBL_WIDTH: r_cfg.tbl_width <= i_cfg_wdata[LEN_W-1:0];
                CFG_TBL_LEN:   r_cfg.tbl_len   <= i_cfg_wdata[LEN_W-1:0];
                CFG_SIDE_OFS:  r_cfg.side_ofs  <= i_cfg_wdata[OFS_W-1:0];
                CFG_FRONT_OFS: r_cfg.front_ofs <= i_cfg_wdata[OFS_W-1:0];
                CFG_BACK_OFS:  r_cfg.back_ofs  <= i_cfg_wdata[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The chain moves unless a shown result is being held by the receiver.
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    wrpe_prep #(
        .FRAC_BITS(FRAC_BITS)
    ) u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_valid         (i_in_valid),
        .i_cfg           (r_cfg),
        .i_ir_front_left (i_ir_front_left),
        .i_ir_front_right(i_ir_front_right),
        .i_ir_back_left  (i_ir_back_left),
        .i_ir_back_right (i_ir_back_right),
        .i_sonar_range   (i_sonar_range),
        .o_valid         (cell_valid[0]),
        .o_stage         (cell_stage[0])
    );

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
        wrpe_cell #(
            .STEP(gi)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_valid(cell_valid[gi]),
            .i_stage(cell_stage[gi]),
            .o_valid(cell_valid[gi+1]),
            .o_stage(cell_stage[gi+1])
        );
    end

    wrpe_post #(
        .FRAC_BITS(FRAC_BITS)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (cell_valid[CORDIC_STEPS]),
        .i_stage     (cell_stage[CORDIC_STEPS]),
        .o_valid     (o_out_valid),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_heading   (o_heading),
        .o_front_wall(o_front_wall)
    );

endmodule

### rtl/core/wrpe_checker.sv
`timescale 1ns / 1ps
module wrpe_checker import wrpe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [POS_W-1:0] o_pos_x,
    input logic signed [POS_W-1:0] o_pos_y,
    input logic signed [HDG_W-1:0] o_heading,
    input logic                    o_front_wall
);

    localparam int R_MAX  = 90 << FRAC_BITS;
    localparam int HDG_HI = (R_MAX > 2047) ? 2047 : R_MAX;
    localparam int HDG_LO = (R_MAX > 2048) ? -2048 : -R_MAX;

    // The input side only waits on a result that the receiver is holding.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_heading) && $stable(o_front_wall)))
        else $error("stalled result changed");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_heading) <= HDG_HI && $signed(o_heading) >= HDG_LO))
        else $error("heading beyond a right angle");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

endmodule

bind wall_range_pose_estimator wrpe_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_wrpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pos_x     (o_pos_x),
    .o_pos_y     (o_pos_y),
    .o_heading   (o_heading),
    .o_front_wall(o_front_wall)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import wrpe_pkg::*;

    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_PRINTED   = 40;
    localparam int RANGE_MAX     = 8191;
    localparam logic [CFG_AW-1:0] CFG_NO_REG = 3'd7;

    // atan(2^-i) in degrees scaled by 2^12, rounded to nearest.
    localparam longint ATAN_STEP [CORDIC_STEPS] = '{
        184320, 108810, 57492, 29184, 14649, 7331, 3667,
        1833, 917, 458, 229, 115, 57, 29
    };

    typedef struct packed {
        logic [RNG_W-1:0] front_left;
        logic [RNG_W-1:0] front_right;
        logic [RNG_W-1:0] back_left;
        logic [RNG_W-1:0] back_right;
        logic [RNG_W-1:0] sonar;
    } t_reading;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [HDG_W-1:0] heading;
        logic                    front_wall;
    } t_pose;

    typedef struct packed {
        t_reading rd;
        logic     typed;
        t_pose    want;
    } t_stim_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_AW-1:0]       i_cfg_addr;
    logic [CFG_DW-1:0]       i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [RNG_W-1:0]        i_ir_front_left;
    logic [RNG_W-1:0]        i_ir_front_right;
    logic [RNG_W-1:0]        i_ir_back_left;
    logic [RNG_W-1:0]        i_ir_back_right;
    logic [RNG_W-1:0]        i_sonar_range;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic signed [HDG_W-1:0] o_heading;
    logic                    o_front_wall;

    t_cfg      cfg_model;
    t_pose     pending_poses[$];
    t_stim_row directed_rows[$];
    logic      typed_on;
    t_pose     typed_pose;
    logic      jitter_on;
    int        holds_requested;
    int        holds_done;
    int        mismatches;
    int        readings_sent;
    int        poses_checked;
    int        settings_used;
    int        cycle_count;

    wall_range_pose_estimator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_ir_front_left  (i_ir_front_left),
        .i_ir_front_right (i_ir_front_right),
        .i_ir_back_left   (i_ir_back_left),
        .i_ir_back_right  (i_ir_back_right),
        .i_sonar_range    (i_sonar_range),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_heading        (o_heading),
        .o_front_wall     (o_front_wall)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Vectoring CORDIC on (10 cm, |d|); result in 1/16 degree, signed like d.
    function automatic longint wall_angle(longint d);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint r;
        int     sh;
        if (d == 0) return 0;
        x = (longint'(10) << FRAC) << CORDIC_GUARD;
        y = (d < 0 ? -d : d) << CORDIC_GUARD;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        sh = ANGLE_FRAC - FRAC;
        r = (z + (sh > 0 ? (longint'(1) << (sh - 1)) : 0)) >>> sh;
        r = clip(r, 0, longint'(90) << FRAC);
        return d < 0 ? -r : r;
    endfunction

    function automatic t_pose estimate_pose(t_reading rd);
        longint fl;
        longint fr;
        longint bl;
        longint br;
        longint sn;
        longint thr;
        longint tw;
        longint so;
        longint left2;
        longint right2;
        longint px;
        longint py;
        longint hd;
        bit     front;
        bit     left;
        bit     right;
        t_pose  p;
        fl = rd.front_left;
        fr = rd.front_right;
        bl = rd.back_left;
        br = rd.back_right;
        sn = rd.sonar;
        thr = cfg_model.ir_thr;
        tw = cfg_model.tbl_width;
        so = cfg_model.side_ofs;
        front = sn < longint'(cfg_model.sonar_thr);
        left = fl < thr || bl < thr;
        right = fr < thr || br < thr;
        // Doubled side estimates keep half units exact until the final rounding.
        left2 = fl + bl + 2 * so;
        right2 = 2 * tw - (fr + br) - 2 * so;
        py = front ? sn + longint'(cfg_model.front_ofs)
                   : longint'(cfg_model.tbl_len) - longint'(cfg_model.back_ofs);
        if (left && !right)
            px = (left2 + 1) >>> 1;
        else if (right && !left)
            px = (right2 + 1) >>> 1;
        else if (left && right)
            px = (left2 + right2 + 2) >>> 2;
        else
            px = (tw + 1) >>> 1;
        if (left)
            hd = wall_angle(fl - bl);
        else if (right)
            hd = -wall_angle(fr - br);
        else
            hd = 0;
        p.pos_x = POS_W'(clip(px, -16384, 16383));
        p.pos_y = POS_W'(clip(py, -16384, 16383));
        p.heading = HDG_W'(clip(hd, -2048, 2047));
        p.front_wall = front;
        return p;
    endfunction

    function automatic logic [RNG_W-1:0] pick_range(int thr);
        longint v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, RANGE_MAX));
            3, 4:    v = (thr == 0) ? 0 : int'($urandom_range(0, thr - 1));
            5:       v = thr + int'($urandom_range(0, 8)) - 4;
            6:       v = $urandom_range(0, 1) ? RANGE_MAX : 0;
            default: v = int'($urandom_range(0, 600));
        endcase
        return RNG_W'(clip(v, 0, RANGE_MAX));
    endfunction

    function automatic t_reading random_reading();
        t_reading rd;
        int       thr;
        thr = int'(cfg_model.ir_thr);
        rd.front_left = pick_range(thr);
        rd.front_right = pick_range(thr);
        rd.back_left = pick_range(thr);
        rd.back_right = pick_range(thr);
        rd.sonar = pick_range(int'(cfg_model.sonar_thr));
        // Sensors on one side usually read close together, as against a real wall.
        if ($urandom_range(0, 99) < 35)
            rd.back_left = RNG_W'(clip(longint'(rd.front_left)
                                       + int'($urandom_range(0, 80)) - 40, 0, RANGE_MAX));
        if ($urandom_range(0, 99) < 35)
            rd.back_right = RNG_W'(clip(longint'(rd.front_right)
                                        + int'($urandom_range(0, 80)) - 40, 0, RANGE_MAX));
        return rd;
    endfunction

    task automatic report(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_pose();
        t_pose want;
        if (pending_poses.size() == 0) begin
            report("pose transaction arrived with none outstanding");
        end else begin
            want = pending_poses.pop_front();
            if (o_pos_x !== want.pos_x)
                report($sformatf("pose %0d pos_x %0d, expected %0d",
                                 poses_checked, o_pos_x, want.pos_x));
            if (o_pos_y !== want.pos_y)
                report($sformatf("pose %0d pos_y %0d, expected %0d",
                                 poses_checked, o_pos_y, want.pos_y));
            if (o_heading !== want.heading)
                report($sformatf("pose %0d heading %0d, expected %0d",
                                 poses_checked, o_heading, want.heading));
            if (o_front_wall !== want.front_wall)
                report($sformatf("pose %0d front_wall %0b, expected %0b",
                                 poses_checked, o_front_wall, want.front_wall));
        end
        poses_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                check_pose();
            if (i_in_valid && !o_in_stall) begin
                pending_poses.push_back(typed_on ? typed_pose
                    : estimate_pose({i_ir_front_left, i_ir_front_right, i_ir_back_left,
                                     i_ir_back_right, i_sonar_range}));
                readings_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d poses outstanding",
                     cycle_count, pending_poses.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: random stalls, plus long hold-offs on request from the sender.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_requested > holds_done) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                i_out_stall = jitter_on && ($urandom_range(0, 99) < 7);
            end
        end
    end

    task automatic offer(input t_reading rd, input logic typed, input t_pose want);
        @(negedge i_clk);
        while (jitter_on && $urandom_range(0, 99) < 7) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_ir_front_left = rd.front_left;
        i_ir_front_right = rd.front_right;
        i_ir_back_left = rd.back_left;
        i_ir_back_right = rd.back_right;
        i_sonar_range = rd.sonar;
        typed_on = typed;
        typed_pose = want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            offer(random_reading(), 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        case (idx)
            CFG_IR_THR:    cfg_model.ir_thr = val[RNG_W-1:0];
            CFG_SONAR_THR: cfg_model.sonar_thr = val[RNG_W-1:0];
            CFG_TBL_WIDTH: cfg_model.tbl_width = val[LEN_W-1:0];
            CFG_TBL_LEN:   cfg_model.tbl_len = val[LEN_W-1:0];
            CFG_SIDE_OFS:  cfg_model.side_ofs = val[OFS_W-1:0];
            CFG_FRONT_OFS: cfg_model.front_ofs = val[OFS_W-1:0];
            CFG_BACK_OFS:  cfg_model.back_ofs = val[OFS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all_regs(input logic [CFG_DW-1:0] val);
        write_reg(CFG_IR_THR, val);
        write_reg(CFG_SONAR_THR, val);
        write_reg(CFG_TBL_WIDTH, val);
        write_reg(CFG_TBL_LEN, val);
        write_reg(CFG_SIDE_OFS, val);
        write_reg(CFG_FRONT_OFS, val);
        write_reg(CFG_BACK_OFS, val);
        settings_used++;
    endtask

    task automatic add_row(input int fl, input int fr, input int bl, input int br,
                           input int sn, input logic typed, input int px = 0,
                           input int py = 0, input int hd = 0, input logic fw = 1'b0);
        t_stim_row row;
        row.rd = {RNG_W'(fl), RNG_W'(fr), RNG_W'(bl), RNG_W'(br), RNG_W'(sn)};
        row.typed = typed;
        row.want = {POS_W'(px), POS_W'(py), HDG_W'(hd), fw};
        directed_rows.push_back(row);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_IR_THR;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_ir_front_left = '0;
        i_ir_front_right = '0;
        i_ir_back_left = '0;
        i_ir_back_right = '0;
        i_sonar_range = '0;
        typed_on = 1'b0;
        typed_pose = '0;
        jitter_on = 1'b1;
        holds_requested = 0;
        holds_done = 0;
        mismatches = 0;
        readings_sent = 0;
        poses_checked = 0;
        settings_used = 1;
        cycle_count = 0;
        cfg_model.ir_thr = 240;
        cfg_model.sonar_thr = 800;
        cfg_model.tbl_width = 1600;
        cfg_model.tbl_len = 3200;
        cfg_model.side_ofs = 48;
        cfg_model.front_ofs = 184;
        cfg_model.back_ofs = 184;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        //      front_left front_right back_left back_right sonar typed  x  y  hdg wall
        add_row(8191, 8191, 8191, 8191, 8191, 1'b1, 800, 3016, 0, 1'b0);
        add_row(0,    0,    0,    0,    0,    1'b1, 800, 184,  0, 1'b1);
        add_row(8191, 8191, 8191, 8191, 799,  1'b1, 800, 983,  0, 1'b1);
        add_row(8191, 8191, 8191, 8191, 800,  1'b1, 800, 3016, 0, 1'b0);
        add_row(100,  8191, 100,  8191, 8191, 1'b1, 148, 3016, 0, 1'b0);
        add_row(8191, 100,  8191, 100,  8191, 1'b1, 1452, 3016, 0, 1'b0);
        add_row(240,  240,  240,  240,  8191, 1'b1, 800, 3016, 0, 1'b0);
        add_row(239,  8191, 8191, 8191, 8191, 1'b0);
        add_row(8191, 8191, 239,  8191, 8191, 1'b0);
        add_row(0,    8191, 8191, 8191, 0,    1'b0);
        add_row(8191, 0,    8191, 8191, 8191, 1'b0);
        add_row(8191, 8191, 8191, 0,    8191, 1'b0);
        add_row(8191, 200,  8191, 100,  300,  1'b0);
        add_row(100,  8191, 116,  8191, 8191, 1'b0);
        add_row(100,  8191, 260,  8191, 8191, 1'b0);
        add_row(1,    8191, 0,    8191, 8191, 1'b0);
        add_row(50,   70,   60,   90,   8191, 1'b0);
        add_row(50,   90,   60,   70,   0,    1'b0);
        add_row(5461, 2730, 5461, 2730, 5461, 1'b0);
        add_row(2730, 5461, 2730, 5461, 2730, 1'b0);
        foreach (directed_rows[k])
            offer(directed_rows[k].rd, directed_rows[k].typed, directed_rows[k].want);

        send_random(200);
        // Long hold-off at the output while the sender keeps going.
        holds_requested++;
        send_random(150);
        wait_drained();

        write_reg(CFG_IR_THR, CFG_DW'($urandom_range(0, 16383)));
        write_reg(CFG_SONAR_THR, CFG_DW'($urandom_range(0, 16383)));
        write_reg(CFG_TBL_WIDTH, CFG_DW'($urandom_range(0, 16383)));
        write_reg(CFG_TBL_LEN, CFG_DW'($urandom_range(0, 16383)));
        write_reg(CFG_SIDE_OFS, CFG_DW'($urandom_range(0, 16383)));
        write_reg(CFG_FRONT_OFS, CFG_DW'($urandom_range(0, 16383)));
        write_reg(CFG_BACK_OFS, CFG_DW'($urandom_range(0, 16383)));
        settings_used++;
        jitter_on = 1'b0;
        send_random(150);
        jitter_on = 1'b1;
        send_random(150);
        wait_drained();

        write_all_regs('1);
        // A write to an index past the register list must leave everything as is.
        write_reg(CFG_NO_REG, '0);
        send_random(150);
        wait_drained();

        write_all_regs('0);
        write_reg(CFG_NO_REG, '1);
        send_random(100);
        wait_drained();

        write_reg(CFG_IR_THR, CFG_DW'($urandom_range(150, 600)));
        write_reg(CFG_SONAR_THR, CFG_DW'($urandom_range(400, 1600)));
        write_reg(CFG_TBL_WIDTH, CFG_DW'($urandom_range(1000, 4000)));
        write_reg(CFG_TBL_LEN, CFG_DW'($urandom_range(2000, 8000)));
        write_reg(CFG_SIDE_OFS, CFG_DW'($urandom_range(0, 300)));
        write_reg(CFG_FRONT_OFS, CFG_DW'($urandom_range(0, 300)));
        write_reg(CFG_BACK_OFS, CFG_DW'($urandom_range(0, 300)));
        settings_used++;
        send_random(150);
        // Sender pauses until every outstanding pose has come back.
        wait_drained();
        send_random(100);
        holds_requested++;
        send_random(150);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_poses.size() != 0)
            report($sformatf("%0d poses never arrived", pending_poses.size()));
        $display("Sent %0d sensor transactions and checked %0d poses over %0d register settings,",
                 readings_sent, poses_checked, settings_used);
        $display("with random idling, long output hold-offs and drain pauses; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
